// File: hdl/lkvc_pkg.sv
// shared types, constants and codes for the lru keyed vector cache
package lkvc_pkg;

	localparam int ENTRIES   = 16;
	localparam int MAX_WORDS = 16;
	localparam int KEY_BITS  = 32;
	localparam int DATA_W    = 64;
	localparam int CFG_W     = 5;

	localparam int SLOT_W = $clog2(ENTRIES);
	localparam int RANK_W = SLOT_W;
	localparam int CNT_W  = $clog2(ENTRIES + 1);
	localparam int POS_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int WCNT_W = $clog2(MAX_WORDS + 1);
	localparam int ADDR_W = $clog2(ENTRIES * MAX_WORDS);

	typedef enum logic [1:0] {
		CMD_PUT   = 2'd0,
		CMD_GET   = 2'd1,
		CMD_PROBE = 2'd2
	} cmd_t;

	typedef enum logic {
		REG_MAX_ENTRIES = 1'b0,
		REG_VALUE_WORDS = 1'b1
	} reg_idx_t;

	// update request from the command stage to the tag array
	typedef struct packed {
		logic touch;
		logic alloc;
	} tag_upd_t;

	// lookup answer from the tag array
	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
	} tag_res_t;

endpackage

// File: hdl/lkvc_vram.sv
// value word memory, one write port and one registered read port
module lkvc_vram
	import lkvc_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [ENTRIES*MAX_WORDS];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: hdl/lkvc_tags.sv
// key tags, valid bits, recency ranks and entry count
module lkvc_tags
	import lkvc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [KEY_BITS-1:0] key,
	input  logic [CNT_W-1:0]    limit,
	input  tag_upd_t            upd,
	output tag_res_t            res,
	output logic [CNT_W-1:0]    count
);

	logic [KEY_BITS-1:0] key_q   [ENTRIES];
	logic [RANK_W-1:0]   rank_q  [ENTRIES];
	logic [ENTRIES-1:0]  valid_q;
	logic [CNT_W-1:0]    count_q;

	logic [ENTRIES-1:0] match;
	logic [SLOT_W-1:0]  hit_slot;
	logic [SLOT_W-1:0]  free_slot;
	logic [SLOT_W-1:0]  victim_slot;
	logic [SLOT_W-1:0]  upd_slot;
	logic [RANK_W-1:0]  old_rank;
	logic [RANK_W-1:0]  oldest;
	logic               free_ok;
	logic               age_all;

	assign oldest  = RANK_W'(count_q - CNT_W'(1));
	assign free_ok = count_q < limit;

	always_comb begin
		hit_slot    = '0;
		free_slot   = '0;
		victim_slot = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			match[i] = valid_q[i] && (key_q[i] == key);
			if (match[i]) hit_slot = SLOT_W'(i);
			if (!valid_q[i]) free_slot = SLOT_W'(i);
			if (valid_q[i] && rank_q[i] == oldest) victim_slot = SLOT_W'(i);
		end
	end

	assign res.hit  = |match;
	assign res.slot = res.hit ? hit_slot : (free_ok ? free_slot : victim_slot);
	assign upd_slot = res.slot;
	assign old_rank = rank_q[upd_slot];
	// a fresh slot ages every other entry
	assign age_all  = upd.alloc && free_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			for (int i = 0; i < ENTRIES; i++) rank_q[i] <= '0;
		end else if (upd.touch || upd.alloc) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (SLOT_W'(i) == upd_slot) begin
					rank_q[i] <= '0;
				end else if (valid_q[i] && (age_all || rank_q[i] < old_rank)) begin
					rank_q[i] <= rank_q[i] + RANK_W'(1);
				end
			end
			if (age_all) begin
				valid_q[upd_slot] <= 1'b1;
				count_q           <= count_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.alloc) begin
			key_q[upd_slot] <= key;
		end
	end

	assign count = count_q;

endmodule

// File: hdl/lru_keyed_vector_cache_unit.sv
// top level of the lru keyed vector cache
// Fully associative LRU store mapping a key to a vector of 64-bit words.
// Input channel: in_valid / in_stall with cmd, key, data; a transfer is
// taken when in_valid is high and in_stall low. Output channel: out_valid
// / out_stall with hit, data_out, last, occupancy.
// A put is a run of value_words transfers, one word each, and gives no
// result. A get hit gives value_words results, last on the final one; a
// get miss or a probe gives one result. cmd 3 is dropped.
// Items enter an input register and are processed from there. Puts,
// probes and get misses sustain one item per cycle unless a word stream
// or, for probes and get misses, a stalled output holds them; a get hit
// holds the input while its words go out, one word per cycle while the
// output is not stalled, out of the single read port of the value memory.
// Results pass the input and output registers; hit words the streamer too.
// A stalled receiver freezes the output register; the input register
// keeps accepting until an item needs the output.
// Reset (arst_n low) empties the cache and sets max_entries and
// value_words to 16; no clearing pass is needed.
// Config writes (cfg_we, cfg_addr, cfg_wdata) only while idle.
module lru_keyed_vector_cache_unit
	import lkvc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_addr,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          cmd,
	input  logic [31:0]         key,
	input  logic [DATA_W-1:0]   data,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                hit,
	output logic [DATA_W-1:0]   data_out,
	output logic                last,
	output logic [CNT_W-1:0]    occupancy
);

	// configuration
	logic [CFG_W-1:0] max_entries_q;
	logic [CFG_W-1:0] value_words_q;
	logic [CNT_W-1:0] limit;
	logic [WCNT_W-1:0] words;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= CFG_W'(16);
			value_words_q <= CFG_W'(16);
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_addr))
				REG_MAX_ENTRIES: max_entries_q <= cfg_wdata;
				REG_VALUE_WORDS: value_words_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign limit = (32'(max_entries_q) > ENTRIES) ? CNT_W'(ENTRIES) : CNT_W'(max_entries_q);
	always_comb begin
		if (value_words_q == '0) words = WCNT_W'(1);
		else if (32'(value_words_q) > MAX_WORDS) words = WCNT_W'(MAX_WORDS);
		else words = WCNT_W'(value_words_q);
	end

	// input register
	logic                s1_valid_s1;
	logic [1:0]          cmd_s1;
	logic [KEY_BITS-1:0] key_s1;
	logic [DATA_W-1:0]   data_s1;

	// put run, streamer and output register
	logic [POS_W-1:0]  put_pos_q;
	logic [SLOT_W-1:0] put_slot_q;
	logic              str_act_q;
	logic [SLOT_W-1:0] str_slot_q;
	logic [POS_W-1:0]  str_pos_q;
	logic              out_valid_q;
	logic              hit_q;
	logic              last_q;
	logic              sel_q;
	logic [CNT_W-1:0]  occ_q;

	tag_res_t          res;
	tag_upd_t          upd;
	logic [CNT_W-1:0]  count;
	logic [DATA_W-1:0] rdata;

	logic              is_put, is_get, is_probe;
	logic              needs_out, out_free, s1_go;
	logic              put_en, put_first;
	logic [POS_W-1:0]  pos_eff;
	logic [SLOT_W-1:0] wr_slot;
	logic              str_issue, str_last;
	logic [ADDR_W-1:0] waddr, raddr;

	assign is_put   = cmd_s1 == CMD_PUT;
	assign is_get   = cmd_s1 == CMD_GET;
	assign is_probe = cmd_s1 == CMD_PROBE;

	assign out_free  = !out_valid_q || !out_stall;
	assign needs_out = (is_get && !res.hit) || is_probe;
	assign s1_go     = s1_valid_s1 && !str_act_q && (!needs_out || out_free);
	assign in_stall  = s1_valid_s1 && !s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			s1_valid_s1 <= 1'b1;
		end else if (s1_go) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_s1  <= cmd;
			key_s1  <= KEY_BITS'(key);
			data_s1 <= data;
		end
	end

	// a run position at or past the length restarts the run
	assign pos_eff   = ({1'b0, put_pos_q} >= (POS_W+1)'(words)) ? '0 : put_pos_q;
	assign put_en    = s1_go && is_put && (limit != '0);
	assign put_first = pos_eff == '0;
	assign wr_slot   = put_first ? res.slot : put_slot_q;

	assign upd.touch = res.hit && ((put_en && put_first) || (s1_go && is_get));
	assign upd.alloc = !res.hit && put_en && put_first;

	lkvc_tags u_tags (
		.clk    (clk),
		.arst_n (arst_n),
		.key    (key_s1),
		.limit  (limit),
		.upd    (upd),
		.res    (res),
		.count  (count)
	);

	assign waddr = ADDR_W'(32'(wr_slot) * MAX_WORDS + 32'(pos_eff));
	assign raddr = ADDR_W'(32'(str_slot_q) * MAX_WORDS + 32'(str_pos_q));

	lkvc_vram u_vram (
		.clk   (clk),
		.we    (put_en),
		.waddr (waddr),
		.wdata (data_s1),
		.re    (str_issue),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			put_pos_q  <= '0;
			put_slot_q <= '0;
		end else if (put_en) begin
			if (put_first) put_slot_q <= res.slot;
			if (WCNT_W'(pos_eff) + WCNT_W'(1) >= words) put_pos_q <= '0;
			else put_pos_q <= pos_eff + POS_W'(1);
		end
	end

	// streamer: one word read per cycle while the output can take it
	assign str_issue = str_act_q && out_free;
	assign str_last  = (WCNT_W'(str_pos_q) + WCNT_W'(1)) == words;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			str_act_q  <= 1'b0;
			str_slot_q <= '0;
			str_pos_q  <= '0;
		end else if (s1_go && is_get && res.hit) begin
			str_act_q  <= 1'b1;
			str_slot_q <= res.slot;
			str_pos_q  <= '0;
		end else if (str_issue) begin
			str_pos_q <= str_pos_q + POS_W'(1);
			if (str_last) str_act_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (str_issue || (s1_go && needs_out)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (str_issue) begin
			hit_q  <= 1'b1;
			last_q <= str_last;
			sel_q  <= 1'b1;
			occ_q  <= count;
		end else if (s1_go && needs_out) begin
			hit_q  <= res.hit;
			last_q <= 1'b1;
			sel_q  <= 1'b0;
			occ_q  <= count;
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign last      = last_q;
	assign occupancy = occ_q;
	assign data_out  = sel_q ? rdata : '0;

`ifndef NO_ASSERTIONS
	a_stream_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		str_act_q |-> !s1_go)
		else $error("input stage advanced during a word stream");
	a_miss_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> last)
		else $error("miss result not marked last");
	a_miss_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> data_out == '0)
		else $error("miss result carries data");
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CNT_W'(ENTRIES))
		else $error("entry count out of range");
`endif

endmodule
